// ===== design/bfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int HEADER_BYTES = 8;
    localparam int PAGE_SHIFT   = 12;
    localparam int MAX_PAGES    = 256;
    localparam int ADDR_W       = 20;
    localparam int ENTRY_W      = 2 * ADDR_W + 1;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOINIT  = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_NOFIT   = 3'd3,
        ST_BADADDR = 3'd4,
        ST_AGAIN   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHU,
        S_AWR1,
        S_AWR2,
        S_FWR,
        S_SHD,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== design/best_fit_block_allocator_top.sv =====
// Processing: an item that needs no table walk goes straight to the result; others
// scan the block table once, and a table insert or delete then moves the
// entries above the chosen block.
// Throughput: one item at a time; the single-read, single-write table memory
// sets the pace. A finished result may wait in the output register while the
// next item is taken. Reset (synchronous, active low) clears control state and
// marks the region uninitialized; the table memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_block_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire logic [8:0]  i_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [19:0] i_request_bytes,
    input  wire logic [19:0] i_free_addr,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [19:0]      o_payload_addr
);

    localparam int AW = bfa_pkg::ADDR_W;
    localparam int IW = bfa_pkg::IDX_W;
    localparam int CW = bfa_pkg::CNT_W;
    localparam int EW = bfa_pkg::ENTRY_W;

    // table memory: {offset, size, busy}
    logic [EW-1:0] mem [bfa_pkg::MAX_BLOCKS];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    bfa_pkg::t_state r_state, n_state;
    logic [8:0]      r_pages;
    logic            r_init, n_init;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [IW-1:0]   r_pidx, n_pidx;
    bfa_pkg::t_mode  r_mode, n_mode;
    logic [AW:0]     r_need, n_need;
    logic [AW-1:0]   r_faddr, n_faddr;
    logic            r_found, n_found;
    logic [IW-1:0]   r_bidx, n_bidx;
    logic [AW-1:0]   r_boff, n_boff;
    logic [AW-1:0]   r_bsize, n_bsize;
    logic [EW-1:0]   r_last, n_last;
    logic [EW-1:0]   r_prev, n_prev;
    logic [EW-1:0]   r_next, n_next;
    logic            r_nok, n_nok;
    logic            r_split, n_split;
    logic [1:0]      r_dist, n_dist;
    logic [2:0]      r_res_stat, n_res_stat;
    logic [AW-1:0]   r_res_addr, n_res_addr;
    logic            r_ovalid, n_ovalid;
    logic [2:0]      r_ostat, n_ostat;
    logic [AW-1:0]   r_oaddr, n_oaddr;

    logic            accept;
    logic            issue;
    logic [AW-1:0]   rd_off;
    logic [AW-1:0]   rd_size;
    logic            rd_busy;
    logic [9:0]      sat_pages;
    logic [AW:0]     region_bytes;
    logic            out_free;
    logic            prev_free;
    logic            next_free;

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != bfa_pkg::S_IDLE);
    assign rd_off    = r_rd[EW-1 -: AW];
    assign rd_size   = r_rd[AW -: AW];
    assign rd_busy   = r_rd[0];
    assign out_free  = !r_ovalid || !i_stall;
    assign prev_free = (r_bidx != '0) && !r_prev[0];
    assign next_free = r_nok && !r_next[0];

    // saturate region to the page limit and byte limit
    always_comb begin
        if ({1'b0, r_pages} > 10'(bfa_pkg::MAX_PAGES)) begin
            sat_pages = 10'(bfa_pkg::MAX_PAGES);
        end else begin
            sat_pages = {1'b0, r_pages};
        end
        if ((sat_pages << bfa_pkg::PAGE_SHIFT) > 22'(1 << AW)) begin
            region_bytes = (AW+1)'(1 << AW);
        end else begin
            region_bytes = (AW+1)'(22'(sat_pages) << bfa_pkg::PAGE_SHIFT);
        end
    end

    // issue condition per sweep
    always_comb begin
        case (r_state)
            bfa_pkg::S_SCAN: issue = (r_idx < r_count);
            bfa_pkg::S_SHD:  issue = (r_idx < r_count);
            bfa_pkg::S_SHU:  issue = (r_idx > (CW'(r_bidx) + CW'(1)));
            default:         issue = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bfa_pkg::S_IDLE: begin
                if (accept) begin
                    if ((i_mode == bfa_pkg::MODE_ALLOC) && r_init && (i_request_bytes != '0)) begin
                        n_state = bfa_pkg::S_SCAN;
                    end else if ((i_mode == bfa_pkg::MODE_FREE) && r_init) begin
                        n_state = bfa_pkg::S_SCAN;
                    end else begin
                        n_state = bfa_pkg::S_FIN;
                    end
                end
            end
            bfa_pkg::S_SCAN: begin
                if (!issue && !r_pend) n_state = bfa_pkg::S_DECIDE;
            end
            bfa_pkg::S_DECIDE: begin
                if (!r_found) begin
                    n_state = bfa_pkg::S_FIN;
                end else if (r_mode == bfa_pkg::MODE_FREE) begin
                    n_state = bfa_pkg::S_FWR;
                end else if (n_split) begin
                    n_state = bfa_pkg::S_SHU;
                end else begin
                    n_state = bfa_pkg::S_AWR1;
                end
            end
            bfa_pkg::S_SHU: begin
                if (!issue && !r_pend) n_state = bfa_pkg::S_AWR1;
            end
            bfa_pkg::S_AWR1: begin
                n_state = r_split ? bfa_pkg::S_AWR2 : bfa_pkg::S_FIN;
            end
            bfa_pkg::S_AWR2: n_state = bfa_pkg::S_FIN;
            bfa_pkg::S_FWR: begin
                n_state = (prev_free || next_free) ? bfa_pkg::S_SHD : bfa_pkg::S_FIN;
            end
            bfa_pkg::S_SHD: begin
                if (!issue && !r_pend) n_state = bfa_pkg::S_FIN;
            end
            bfa_pkg::S_FIN: begin
                if (out_free) n_state = bfa_pkg::S_IDLE;
            end
            default: n_state = bfa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_init     = r_init;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        n_mode     = r_mode;
        n_need     = r_need;
        n_faddr    = r_faddr;
        n_found    = r_found;
        n_bidx     = r_bidx;
        n_boff     = r_boff;
        n_bsize    = r_bsize;
        n_last     = r_last;
        n_prev     = r_prev;
        n_next     = r_next;
        n_nok      = r_nok;
        n_split    = r_split;
        n_dist     = r_dist;
        n_res_stat = r_res_stat;
        n_res_addr = r_res_addr;
        n_ovalid   = r_ovalid && i_stall;
        n_ostat    = r_ostat;
        n_oaddr    = r_oaddr;
        mem_we     = 1'b0;
        mem_waddr  = r_pidx;
        mem_wdata  = r_rd;
        mem_raddr  = r_idx[IW-1:0];

        case (r_state)
            bfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_mode     = bfa_pkg::t_mode'(i_mode);
                    n_need     = ({1'b0, i_request_bytes} + (AW+1)'(3)) & ~(AW+1)'(3);
                    n_faddr    = i_free_addr;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_nok      = 1'b0;
                    n_res_stat = bfa_pkg::ST_OK;
                    n_res_addr = '0;
                    case (bfa_pkg::t_mode'(i_mode))
                        bfa_pkg::MODE_ALLOC: begin
                            if (!r_init) n_res_stat = bfa_pkg::ST_NOINIT;
                            else if (i_request_bytes == '0) n_res_stat = bfa_pkg::ST_BADSIZE;
                        end
                        bfa_pkg::MODE_FREE: begin
                            if (!r_init) n_res_stat = bfa_pkg::ST_NOINIT;
                        end
                        bfa_pkg::MODE_INIT: begin
                            if (r_init) begin
                                n_res_stat = bfa_pkg::ST_AGAIN;
                            end else if (r_pages == '0) begin
                                n_res_stat = bfa_pkg::ST_BADSIZE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = {AW'(0),
                                             AW'(region_bytes - (AW+1)'(bfa_pkg::HEADER_BYTES)),
                                             1'b0};
                                n_count   = CW'(1);
                                n_init    = 1'b1;
                            end
                        end
                        default: n_res_stat = bfa_pkg::ST_OK;
                    endcase
                end
            end

            // walk the table once, one entry a cycle
            bfa_pkg::S_SCAN: begin
                mem_raddr = r_idx[IW-1:0];
                n_pend    = issue;
                n_pidx    = r_idx[IW-1:0];
                if (issue) n_idx = r_idx + CW'(1);
                if (r_pend) begin
                    n_last = r_rd;
                    if (r_mode == bfa_pkg::MODE_ALLOC) begin
                        if (!rd_busy && ({1'b0, rd_size} >= r_need)
                            && (!r_found || (rd_size < r_bsize))) begin
                            n_found = 1'b1;
                            n_bidx  = r_pidx;
                            n_boff  = rd_off;
                            n_bsize = rd_size;
                        end
                    end else begin
                        if (!r_found && rd_busy
                            && (({1'b0, rd_off} + (AW+1)'(bfa_pkg::HEADER_BYTES))
                                == {1'b0, r_faddr})) begin
                            n_found = 1'b1;
                            n_bidx  = r_pidx;
                            n_boff  = rd_off;
                            n_bsize = rd_size;
                            n_prev  = r_last;
                        end
                        if (r_found && (CW'(r_pidx) == (CW'(r_bidx) + CW'(1)))) begin
                            n_next = r_rd;
                            n_nok  = 1'b1;
                        end
                    end
                end
            end

            bfa_pkg::S_DECIDE: begin
                n_split = ({2'b0, r_bsize} >= ({1'b0, r_need}
                           + (AW+2)'(bfa_pkg::HEADER_BYTES + 4)))
                          && (r_count < CW'(bfa_pkg::MAX_BLOCKS));
                n_idx   = r_count;
                if (!r_found) begin
                    n_res_stat = (r_mode == bfa_pkg::MODE_FREE) ? bfa_pkg::ST_BADADDR
                                                                 : bfa_pkg::ST_NOFIT;
                end else if (r_mode == bfa_pkg::MODE_ALLOC) begin
                    n_res_addr = r_boff + AW'(bfa_pkg::HEADER_BYTES);
                end
            end

            // move entries above the chosen block up by one
            bfa_pkg::S_SHU: begin
                mem_raddr = IW'(r_idx - CW'(1));
                n_pend    = issue;
                n_pidx    = IW'(r_idx - CW'(1));
                if (issue) n_idx = r_idx - CW'(1);
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pidx + IW'(1);
                    mem_wdata = r_rd;
                end
            end

            bfa_pkg::S_AWR1: begin
                mem_we    = 1'b1;
                mem_waddr = r_bidx;
                mem_wdata = {r_boff, r_split ? r_need[AW-1:0] : r_bsize, 1'b1};
            end

            bfa_pkg::S_AWR2: begin
                mem_we    = 1'b1;
                mem_waddr = r_bidx + IW'(1);
                mem_wdata = {r_boff + AW'(bfa_pkg::HEADER_BYTES) + r_need[AW-1:0],
                             r_bsize - r_need[AW-1:0] - AW'(bfa_pkg::HEADER_BYTES),
                             1'b0};
                n_count   = r_count + CW'(1);
            end

            // write the freed or merged block, then close any gap left by merged neighbors
            bfa_pkg::S_FWR: begin
                mem_we = 1'b1;
                if (prev_free && next_free) begin
                    mem_waddr = r_bidx - IW'(1);
                    mem_wdata = {r_prev[EW-1 -: AW],
                                 r_prev[AW -: AW] + r_bsize + r_next[AW -: AW]
                                 + AW'(2 * bfa_pkg::HEADER_BYTES), 1'b0};
                    n_idx  = CW'(r_bidx) + CW'(2);
                    n_dist = 2'd2;
                end else if (next_free) begin
                    mem_waddr = r_bidx;
                    mem_wdata = {r_boff, r_bsize + r_next[AW -: AW]
                                 + AW'(bfa_pkg::HEADER_BYTES), 1'b0};
                    n_idx  = CW'(r_bidx) + CW'(2);
                    n_dist = 2'd1;
                end else if (prev_free) begin
                    mem_waddr = r_bidx - IW'(1);
                    mem_wdata = {r_prev[EW-1 -: AW], r_prev[AW -: AW] + r_bsize
                                 + AW'(bfa_pkg::HEADER_BYTES), 1'b0};
                    n_idx  = CW'(r_bidx) + CW'(1);
                    n_dist = 2'd1;
                end else begin
                    mem_waddr = r_bidx;
                    mem_wdata = {r_boff, r_bsize, 1'b0};
                end
            end

            // move entries down by the number of merged neighbors
            bfa_pkg::S_SHD: begin
                mem_raddr = r_idx[IW-1:0];
                n_pend    = issue;
                n_pidx    = r_idx[IW-1:0];
                if (issue) n_idx = r_idx + CW'(1);
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pidx - IW'(r_dist);
                    mem_wdata = r_rd;
                end
                if (!issue && !r_pend) n_count = r_count - CW'(r_dist);
            end

            // hand the result to the output register
            bfa_pkg::S_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_res_stat;
                    n_oaddr  = (r_res_stat == bfa_pkg::ST_OK) ? r_res_addr : '0;
                end
            end

            default: n_pend = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfa_pkg::S_IDLE;
            r_pages  <= 9'd1;
            r_init   <= 1'b0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_wr_en) r_pages <= i_wr_data;
            r_init   <= n_init;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_mode     <= n_mode;
        r_need     <= n_need;
        r_faddr    <= n_faddr;
        r_found    <= n_found;
        r_bidx     <= n_bidx;
        r_boff     <= n_boff;
        r_bsize    <= n_bsize;
        r_last     <= n_last;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_nok      <= n_nok;
        r_split    <= n_split;
        r_dist     <= n_dist;
        r_res_stat <= n_res_stat;
        r_res_addr <= n_res_addr;
        r_ostat    <= n_ostat;
        r_oaddr    <= n_oaddr;
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_ostat;
    assign o_payload_addr = r_oaddr;

endmodule
`default_nettype wire
